// ===== design/bmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types, constants and the register index decode for the bank mapper.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    // item kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TICK     = 2'd1,
        OP_CPU_READ = 2'd2,
        OP_PPU_READ = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_VARIANT   = 2'd0;
    localparam logic [1:0] CFG_PRG_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd2;

    // write regions (address bits 15:12)
    localparam logic [3:0] REG_PRG_FIRST  = 4'h8;
    localparam logic [3:0] REG_MIRROR     = 4'h9;
    localparam logic [3:0] REG_PRG_SECOND = 4'hA;
    localparam logic [3:0] REG_CHR_B      = 4'hB;
    localparam logic [3:0] REG_CHR_C      = 4'hC;
    localparam logic [3:0] REG_CHR_D      = 4'hD;
    localparam logic [3:0] REG_CHR_E      = 4'hE;
    localparam logic [3:0] REG_IRQ        = 4'hF;

    // register index within the irq region
    localparam logic [1:0] IRQ_RELOAD_LO = 2'd0;
    localparam logic [1:0] IRQ_RELOAD_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL   = 2'd2;
    localparam logic [1:0] IRQ_ACK       = 2'd3;

    localparam int CHR_SLOTS = 8;

    // prescaler: adds 3 per cpu cycle, wraps once it reaches 338
    localparam logic [8:0] PRESCALE_WRAP = 9'd338;
    localparam logic [8:0] PRESCALE_STEP = 9'd3;
    localparam logic [7:0] COUNTER_MAX   = 8'hFF;

    // reset values of the configuration registers
    localparam logic [2:0] VARIANT_RESET   = 3'd0;
    localparam logic [5:0] PRG_COUNT_RESET = 6'd32;
    localparam logic [9:0] CHR_COUNT_RESET = 10'd512;

    // one decoded item as seen by the state units
    typedef struct packed {
        logic        go;      // item moves to the result stage this cycle
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  idx;     // register index from the board wiring
    } cmd_t;

    // register index from the address lines that the board wiring selects
    function automatic logic [1:0] reg_index(input logic [2:0]  variant,
                                             input logic [15:0] addr);
        logic [1:0] i;
        case (variant)
            3'd1:    i = {addr[0], addr[1]};
            3'd2:    i = {addr[7], addr[6]};
            3'd3:    i = {addr[2], addr[3]};
            3'd4:    i = {addr[3], addr[2]};
            3'd5:    i = {addr[1], addr[0]};
            3'd6:    i = {addr[11], addr[10]};
            default: i = {addr[2], addr[1]};
        endcase
        return i;
    endfunction

endpackage

// ===== design/bmsi_banks.sv =====
// ----------------------------------------------------------------------------
// bmsi_banks
// PRG and CHR bank registers, mirroring, and the bank lookup for one item.
// ----------------------------------------------------------------------------
module bmsi_banks (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmsi_pkg::cmd_t       cmd,
    input  logic [5:0]           prg_count,
    input  logic [9:0]           chr_count,
    output logic [8:0]           bank,
    output logic [1:0]           mirror_next
);
    import bmsi_pkg::*;

    logic [4:0] prg_first_reg,  prg_first_next;
    logic [4:0] prg_second_reg, prg_second_next;
    logic       prg_swap_reg,   prg_swap_next;
    logic [1:0] mirror_reg;
    logic [8:0] chr_reg  [CHR_SLOTS];
    logic [8:0] chr_next [CHR_SLOTS];

    logic       wr;
    logic [2:0] slot;
    logic [5:0] prg_mask;
    logic [5:0] prg_before_last;
    logic [5:0] prg_first_m;
    logic [5:0] prg_bank;
    logic [9:0] chr_mask;

    assign wr   = cmd.go && (cmd.op == OP_WRITE) && cmd.addr[15];
    // regions B..E hold two slots each, picked by index bit 1
    assign slot = {cmd.addr[13:12] + 2'd1, cmd.idx[1]};

    // register write decode
    always_comb
    begin
        prg_first_next  = prg_first_reg;
        prg_second_next = prg_second_reg;
        prg_swap_next   = prg_swap_reg;
        mirror_next     = mirror_reg;
        chr_next        = chr_reg;
        if (wr)
        begin
            case (cmd.addr[15:12])
                REG_PRG_FIRST:  prg_first_next  = cmd.data[4:0];
                REG_PRG_SECOND: prg_second_next = cmd.data[4:0];
                REG_MIRROR:
                begin
                    if (!cmd.idx[1])
                        mirror_next = cmd.data[1:0];
                    else
                        prg_swap_next = cmd.data[1];
                end
                REG_CHR_B, REG_CHR_C, REG_CHR_D, REG_CHR_E:
                begin
                    if (cmd.idx[0])
                        chr_next[slot] = {cmd.data[4:0], chr_reg[slot][3:0]};
                    else
                        chr_next[slot] = {chr_reg[slot][8:4], cmd.data[3:0]};
                end
                default: ;
            endcase
        end
    end

    // bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_first_reg  <= 5'd0;
            prg_second_reg <= 5'd1;
            prg_swap_reg   <= 1'b0;
            mirror_reg     <= 2'd0;
            for (int i = 0; i < CHR_SLOTS; i++)
                chr_reg[i] <= 9'(i);
        end
        else
        begin
            prg_first_reg  <= prg_first_next;
            prg_second_reg <= prg_second_next;
            prg_swap_reg   <= prg_swap_next;
            mirror_reg     <= mirror_next;
            chr_reg        <= chr_next;
        end
    end

    // cpu lookup: two switchable and two fixed 8K slots
    assign prg_mask        = prg_count - 6'd1;
    assign prg_before_last = prg_count - 6'd2;
    assign prg_first_m     = {1'b0, prg_first_reg} & prg_mask;

    always_comb
    begin
        case (cmd.addr[14:13])
            2'd0:    prg_bank = prg_swap_reg ? prg_before_last : prg_first_m;
            2'd1:    prg_bank = {1'b0, prg_second_reg} & prg_mask;
            2'd2:    prg_bank = prg_swap_reg ? prg_first_m : prg_before_last;
            default: prg_bank = prg_mask;
        endcase
    end

    assign chr_mask = chr_count - 10'd1;

    // bank result, zero for writes, ticks and unmapped areas
    always_comb
    begin
        case (cmd.op)
            OP_CPU_READ: bank = cmd.addr[15] ? {3'd0, prg_bank} : 9'd0;
            OP_PPU_READ: bank = cmd.addr[13] ? 9'd0
                                : (chr_reg[cmd.addr[12:10]] & chr_mask[8:0]);
            default:     bank = 9'd0;
        endcase
    end

endmodule

// ===== design/bmsi_irq.sv =====
// ----------------------------------------------------------------------------
// bmsi_irq
// IRQ reload, prescaler and 8-bit counter with pending flag.
// ----------------------------------------------------------------------------
module bmsi_irq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmsi_pkg::cmd_t       cmd,
    output logic                 pending_next
);
    import bmsi_pkg::*;

    logic [7:0] reload_reg,   reload_next;
    logic [7:0] counter_reg,  counter_next;
    logic [8:0] prescale_reg, prescale_next;
    logic       enable_reg,   enable_next;
    logic       cycle_reg,    cycle_next;
    logic       ack_en_reg,   ack_en_next;
    logic       pending_reg;

    logic       wr;
    logic       tick;

    assign wr   = cmd.go && (cmd.op == OP_WRITE) && (cmd.addr[15:12] == REG_IRQ);
    assign tick = cmd.go && (cmd.op == OP_TICK) && enable_reg;

    // control writes and counting
    always_comb
    begin
        reload_next   = reload_reg;
        counter_next  = counter_reg;
        prescale_next = prescale_reg;
        enable_next   = enable_reg;
        cycle_next    = cycle_reg;
        ack_en_next   = ack_en_reg;
        pending_next  = pending_reg;
        if (wr)
        begin
            case (cmd.idx)
                IRQ_RELOAD_LO: reload_next = {reload_reg[7:4], cmd.data[3:0]};
                IRQ_RELOAD_HI: reload_next = {cmd.data[3:0], reload_reg[3:0]};
                IRQ_CONTROL:
                begin
                    ack_en_next  = cmd.data[0];
                    enable_next  = cmd.data[1];
                    cycle_next   = cmd.data[2];
                    pending_next = 1'b0;
                    if (cmd.data[1])
                    begin
                        prescale_next = 9'd0;
                        counter_next  = reload_reg;
                    end
                end
                default:
                begin
                    enable_next  = ack_en_reg;
                    pending_next = 1'b0;
                end
            endcase
        end
        else if (tick)
        begin
            if (!cycle_reg && (prescale_reg < PRESCALE_WRAP))
                prescale_next = prescale_reg + PRESCALE_STEP;
            else
            begin
                if (!cycle_reg)
                    prescale_next = prescale_reg - PRESCALE_WRAP;
                if (counter_reg != COUNTER_MAX)
                    counter_next = counter_reg + 8'd1;
                else
                begin
                    counter_next = reload_reg;
                    pending_next = 1'b1;
                end
            end
        end
    end

    // irq state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= 8'd0;
            counter_reg  <= 8'd0;
            prescale_reg <= 9'd0;
            enable_reg   <= 1'b0;
            cycle_reg    <= 1'b0;
            ack_en_reg   <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            reload_reg   <= reload_next;
            counter_reg  <= counter_next;
            prescale_reg <= prescale_next;
            enable_reg   <= enable_next;
            cycle_reg    <= cycle_next;
            ack_en_reg   <= ack_en_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// ===== design/bank_mapper_with_scanline_irq.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper with CPU-cycle IRQ counter: register writes, ticks,
// CPU and PPU bank lookups, one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | tdata address, data; tuser opcode
//  m       | out       | m_tvalid/m_tready  | tdata bank, irq_line, mirroring
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one beat accepted per cycle unless the result register stalls; m_tvalid
//  rises after input register, then decode and state update into result register
//  a stalled result register holds the input register, which holds s_tready low
//  rst_n clears all mapper state to power-on values; no clearing pass
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bank[8:0], irq_line[9], mirroring[11:10], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import bmsi_pkg::*;

    logic [2:0]  variant_reg;
    logic [5:0]  prg_count_reg;
    logic [9:0]  chr_count_reg;

    logic        in_valid_reg;
    op_t         op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    logic        out_valid_reg;
    logic [8:0]  bank_reg;
    logic        irq_reg;
    logic [1:0]  mirror_reg;

    logic        out_adv;
    logic        fire;
    cmd_t        cmd;
    logic [8:0]  bank;
    logic        pending_next;
    logic [1:0]  mirror_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= VARIANT_RESET;
            prg_count_reg <= PRG_COUNT_RESET;
            chr_count_reg <= CHR_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VARIANT:   variant_reg   <= cfg_data[2:0];
                CFG_PRG_COUNT: prg_count_reg <= cfg_data[5:0];
                CFG_CHR_COUNT: chr_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign out_adv  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= op_t'(s_tuser);
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
    end

    // decoded item for the state units
    always_comb
    begin
        cmd.go   = fire;
        cmd.op   = op_reg;
        cmd.addr = addr_reg;
        cmd.data = data_reg;
        cmd.idx  = reg_index(variant_reg, addr_reg);
    end

    bmsi_banks u_banks (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .prg_count   (prg_count_reg),
        .chr_count   (chr_count_reg),
        .bank        (bank),
        .mirror_next (mirror_next)
    );

    bmsi_irq u_irq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pending_next (pending_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            bank_reg   <= bank;
            irq_reg    <= pending_next;
            mirror_reg <= mirror_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, mirror_reg, irq_reg, bank_reg};

endmodule
